FILE: hdl/mono_framebuffer_dirty_expand_unit_defines.svh
// Assertion macros shared by the frame store design.
`ifndef MONO_FRAMEBUFFER_DIRTY_EXPAND_UNIT_DEFINES_SVH
`define MONO_FRAMEBUFFER_DIRTY_EXPAND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFDE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MFDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mfde_pkg.sv
package mfde_pkg;

  typedef enum logic [1:0] {
    REQ_DRAW   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_COMMIT = 2'd2,
    REQ_READ   = 2'd3
  } req_code_t;

  typedef struct packed {
    req_code_t   req_type;
    logic [9:0]  pix_x;
    logic [9:0]  pix_y;
    logic        pix_white;
    logic [16:0] byte_index;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        changed;
    logic [15:0] expanded_word;
  } rsp_t;

  localparam logic [7:0] BYTE_WHITE = 8'hFF;
  localparam logic [7:0] BYTE_BLACK = 8'h00;

  // Each pixel bit becomes a two-bit code: 00 black, 01 white.
  function automatic logic [7:0] widen_nibble(input logic [3:0] n);
    logic [7:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[2*k] = n[k];
    end
    return r;
  endfunction

endpackage

FILE: hdl/mono_framebuffer_dirty_expand_unit.sv
// Draw and read requests: read, write and done states follow acceptance; rejected ones go to done directly.
// Clear request: a fill pass over the frame store, one frame store byte written per cycle.
// Commit request: a scan pass over both stores, one byte pair compared per cycle.
// One request is in work at a time; the next is taken once the response is loaded and the unit is idle.
// After reset an initialization pass fills both stores, ready low.
`include "mono_framebuffer_dirty_expand_unit_defines.svh"

module mono_framebuffer_dirty_expand_unit #(
  parameter int PANEL_WIDTH  = 200,
  parameter int PANEL_HEIGHT = 200
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  mfde_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output mfde_pkg::rsp_t  rsp
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  typedef enum logic [7:0] {
    S_INIT     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_READ     = 8'b0000_0100,
    S_WRITE    = 8'b0000_1000,
    S_FILL     = 8'b0001_0000,
    S_SCAN     = 8'b0010_0000,
    S_SCAN_END = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t              state;
  logic [ADDR_W-1:0]   cnt;
  logic [ADDR_W-1:0]   addr;
  logic [ADDR_W-1:0]   scan_addr;
  logic                scan_vld;
  logic                diff;
  logic                hit;
  logic                chg;
  logic                white;
  logic [2:0]          bit_sel;
  mfde_pkg::req_code_t op;
  logic [15:0]         word;

  logic [7:0]          frame_mem [STORE_BYTES];
  logic [7:0]          snap_mem  [STORE_BYTES];
  logic [7:0]          frame_q;
  logic [7:0]          snap_q;

  logic                frame_we;
  logic [ADDR_W-1:0]   frame_wa;
  logic [7:0]          frame_wd;
  logic [ADDR_W-1:0]   frame_ra;
  logic                snap_we;
  logic [ADDR_W-1:0]   snap_wa;
  logic [7:0]          snap_wd;

  logic                draw_hit;
  logic                read_hit;
  logic [16:0]         draw_idx;
  logic [7:0]          pix_mask;
  logic                diff_hit;

  assign req_ready = (state == S_IDLE);

  assign draw_hit = ({1'b0, req.pix_x} < 11'(PANEL_WIDTH)) &&
                    ({1'b0, req.pix_y} < 11'(PANEL_HEIGHT));
  assign read_hit = ({1'b0, req.byte_index} < 18'(STORE_BYTES));
  assign draw_idx = 17'(req.pix_y) * 17'(ROW_BYTES) + 17'(req.pix_x[9:3]);

  assign pix_mask = 8'h80 >> bit_sel;
  assign diff_hit = scan_vld && (frame_q != snap_q);
  assign frame_ra = (state == S_SCAN) ? cnt : addr;

  always_comb begin
    frame_we = 1'b0;
    frame_wa = cnt;
    frame_wd = mfde_pkg::BYTE_WHITE;
    snap_we  = 1'b0;
    snap_wa  = cnt;
    snap_wd  = mfde_pkg::BYTE_BLACK;
    case (state)
      S_INIT: begin
        frame_we = 1'b1;
        snap_we  = 1'b1;
      end
      S_FILL: begin
        frame_we = 1'b1;
      end
      S_WRITE: begin
        frame_we = (op == mfde_pkg::REQ_DRAW);
        frame_wa = addr;
        frame_wd = white ? (frame_q | pix_mask) : (frame_q & ~pix_mask);
      end
      default: begin
        frame_we = 1'b0;
      end
    endcase
    if (scan_vld) begin
      snap_we = 1'b1;
      snap_wa = scan_addr;
      snap_wd = frame_q;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_we) begin
      frame_mem[frame_wa] <= frame_wd;
    end
    frame_q <= frame_mem[frame_ra];
  end

  always_ff @(posedge clk) begin
    if (snap_we) begin
      snap_mem[snap_wa] <= snap_wd;
    end
    snap_q <= snap_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      rsp_valid <= 1'b0;
      scan_vld  <= 1'b0;
      diff      <= 1'b0;
    end else begin
      scan_vld  <= (state == S_SCAN);
      scan_addr <= cnt;
      if (diff_hit) begin
        diff <= 1'b1;
      end
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (cnt == LAST_ADDR) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.req_type;
            white   <= req.pix_white;
            bit_sel <= req.pix_x[2:0];
            chg     <= 1'b0;
            word    <= '0;
            diff    <= 1'b0;
            cnt     <= '0;
            case (req.req_type)
              mfde_pkg::REQ_DRAW: begin
                hit   <= draw_hit;
                addr  <= ADDR_W'(draw_idx);
                state <= draw_hit ? S_READ : S_DONE;
              end
              mfde_pkg::REQ_CLEAR: begin
                hit   <= 1'b1;
                state <= S_FILL;
              end
              mfde_pkg::REQ_COMMIT: begin
                hit   <= 1'b1;
                state <= S_SCAN;
              end
              mfde_pkg::REQ_READ: begin
                hit   <= read_hit;
                addr  <= ADDR_W'(req.byte_index);
                state <= read_hit ? S_READ : S_DONE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (op == mfde_pkg::REQ_READ) begin
            word <= {mfde_pkg::widen_nibble(frame_q[7:4]),
                     mfde_pkg::widen_nibble(frame_q[3:0])};
          end
          state <= S_DONE;
        end
        S_FILL: begin
          if (cnt == LAST_ADDR) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        S_SCAN: begin
          if (cnt == LAST_ADDR) begin
            cnt   <= '0;
            state <= S_SCAN_END;
          end else begin
            cnt <= cnt + ADDR_W'(1);
          end
        end
        S_SCAN_END: begin
          chg   <= diff | diff_hit;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.accepted      <= hit;
            rsp.changed       <= chg;
            rsp.expanded_word <= word;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  `MFDE_ASSERT_SAME(a_snap_write_window, clk, rst, snap_we,
                    (state == S_INIT) || scan_vld, "snapshot written outside init or commit")
  `MFDE_ASSERT_SAME(a_frame_still_in_scan, clk, rst, (state == S_SCAN) || (state == S_SCAN_END),
                    !frame_we, "frame store written during commit")
  `MFDE_ASSERT_SAME(a_changed_needs_accept, clk, rst, rsp_valid && rsp.changed,
                    rsp.accepted, "changed response without acceptance")
  `MFDE_ASSERT_SAME(a_word_needs_accept, clk, rst, rsp_valid && (rsp.expanded_word != 16'h0000),
                    rsp.accepted, "expanded word on a rejected request")
  `MFDE_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready,
                    !req_ready, "second request taken while one is in work")

endmodule

FILE: dv/mono_framebuffer_dirty_expand_unit_tb.sv
`timescale 1ns / 1ps

module mono_framebuffer_dirty_expand_unit_tb;

  localparam int PANEL_WIDTH  = 200;
  localparam int PANEL_HEIGHT = 200;
  localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
  localparam int LIMIT_CYCLES = 10000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 107;

  class frame_shadow;
    logic [7:0]     frame_bytes [STORE_BYTES];
    logic [7:0]     snap_bytes [STORE_BYTES];
    mfde_pkg::rsp_t expected_rsp [$];
    int             mismatches;

    function new();
      foreach (frame_bytes[i]) begin
        frame_bytes[i] = mfde_pkg::BYTE_WHITE;
        snap_bytes[i]  = mfde_pkg::BYTE_BLACK;
      end
      mismatches = 0;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function void note_request(mfde_pkg::req_t r);
      mfde_pkg::rsp_t want;
      int unsigned    pos;
      logic [7:0]     bits;
      logic           differ;
      want = '0;
      case (r.req_type)
        mfde_pkg::REQ_DRAW: begin
          if (r.pix_x < PANEL_WIDTH && r.pix_y < PANEL_HEIGHT) begin
            pos = r.pix_y * ROW_BYTES + r.pix_x[9:3];
            frame_bytes[pos][7 - r.pix_x[2:0]] = r.pix_white;
            want.accepted = 1'b1;
          end
        end
        mfde_pkg::REQ_CLEAR: begin
          foreach (frame_bytes[i]) frame_bytes[i] = mfde_pkg::BYTE_WHITE;
          want.accepted = 1'b1;
        end
        mfde_pkg::REQ_COMMIT: begin
          differ = 1'b0;
          foreach (frame_bytes[i]) begin
            if (frame_bytes[i] != snap_bytes[i]) differ = 1'b1;
          end
          if (differ) begin
            foreach (frame_bytes[i]) snap_bytes[i] = frame_bytes[i];
          end
          want.accepted = 1'b1;
          want.changed  = differ;
        end
        mfde_pkg::REQ_READ: begin
          if (r.byte_index < STORE_BYTES) begin
            bits = frame_bytes[r.byte_index];
            for (int k = 0; k < 8; k++) want.expanded_word[2*k] = bits[k];
            want.accepted = 1'b1;
          end
        end
        default: begin
        end
      endcase
      expected_rsp.push_back(want);
    endfunction

    function void check_response(mfde_pkg::rsp_t got);
      mfde_pkg::rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("response with no request outstanding: %0h", got);
        mismatches++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0h, got %0h", want.accepted, got.accepted);
        mismatches++;
      end
      if (got.changed !== want.changed) begin
        $error("changed: expected %0h, got %0h", want.changed, got.changed);
        mismatches++;
      end
      if (got.expanded_word !== want.expanded_word) begin
        $error("expanded_word: expected %0h, got %0h", want.expanded_word,
               got.expanded_word);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  mfde_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  mfde_pkg::rsp_t rsp;

  frame_shadow shadow = new();
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;
  int          cycle_count = 0;

  mono_framebuffer_dirty_expand_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("mono_framebuffer_dirty_expand_unit_tb: FAIL");
      $finish;
    end
  end

  function int draw_gap();
    return idle_on ? $urandom_range(0, 11) : 0;
  endfunction

  function mfde_pkg::req_t make_req(mfde_pkg::req_code_t kind, int x, int y, bit white,
                                    int idx);
    mfde_pkg::req_t r;
    r.req_type   = kind;
    r.pix_x      = x[9:0];
    r.pix_y      = y[9:0];
    r.pix_white  = white;
    r.byte_index = idx[16:0];
    return r;
  endfunction

  // About half of the draws and reads land in the first four rows so that reads see drawn pixels.
  function mfde_pkg::req_t random_request();
    mfde_pkg::req_t r;
    int unsigned    pick;
    r.pix_x      = 10'($urandom_range(0, 1023));
    r.pix_y      = 10'($urandom_range(0, 1023));
    r.pix_white  = 1'($urandom_range(0, 1));
    r.byte_index = 17'($urandom_range(0, 131071));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.req_type = mfde_pkg::REQ_DRAW;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        r.pix_x = 10'($urandom_range(0, PANEL_WIDTH - 1));
        r.pix_y = 10'($urandom_range(0, 3));
      end else if (pick < 80) begin
        r.pix_x = 10'($urandom_range(0, PANEL_WIDTH - 1));
        r.pix_y = 10'($urandom_range(0, PANEL_HEIGHT - 1));
      end
    end else if (pick < 88) begin
      r.req_type = mfde_pkg::REQ_READ;
      pick = $urandom_range(0, 99);
      if (pick < 50) r.byte_index = 17'($urandom_range(0, 4 * ROW_BYTES - 1));
      else if (pick < 85) r.byte_index = 17'($urandom_range(0, STORE_BYTES - 1));
    end else if (pick < 95) begin
      r.req_type = mfde_pkg::REQ_COMMIT;
    end else begin
      r.req_type = mfde_pkg::REQ_CLEAR;
    end
    return r;
  endfunction

  task automatic send_request(input mfde_pkg::req_t r);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    shadow.note_request(r);
  endtask

  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int n;
    do @(posedge clk); while (rst);
    forever begin
      n = draw_gap();
      if (hold_cycles > 0) begin
        n = n + hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        rsp_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      shadow.check_response(rsp);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(mfde_pkg::REQ_COMMIT, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_COMMIT, 1023, 1023, 1'b1, 131071));
    send_request(make_req(mfde_pkg::REQ_DRAW, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_DRAW, PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_DRAW, 7, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_DRAW, PANEL_WIDTH, 0, 1'b1, 0));
    send_request(make_req(mfde_pkg::REQ_DRAW, 0, PANEL_HEIGHT, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_DRAW, 1023, 1023, 1'b0, 131071));
    send_request(make_req(mfde_pkg::REQ_READ, 1023, 1023, 1'b1, 0));
    send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 1'b0, STORE_BYTES - 1));
    send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 1'b0, STORE_BYTES));
    send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 1'b0, 131071));
    send_request(make_req(mfde_pkg::REQ_DRAW, 0, 0, 1'b1, 0));
    send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_COMMIT, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_CLEAR, 1023, 1023, 1'b1, 131071));
    send_request(make_req(mfde_pkg::REQ_COMMIT, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_COMMIT, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_DRAW, 100, 100, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_CLEAR, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_COMMIT, 0, 0, 1'b0, 0));
    send_request(make_req(mfde_pkg::REQ_READ, 0, 0, 1'b0, STORE_BYTES / 2));

    for (int ph = 0; ph < 4; ph++) begin
      idle_on = (ph != 1);
      if (ph == 2) hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < PHASE_ITEMS; i++) send_request(random_request());
      if (ph == 1) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("mono_framebuffer_dirty_expand_unit_tb: PASS");
    end else begin
      $display("mono_framebuffer_dirty_expand_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
